### src/stpr_pkg.sv
// Shared types and constants for the stepper trapezoid profile unit.
`default_nettype none
package stpr_pkg;

  localparam int NUM_AXES_DEF     = 3;
  localparam int PERIOD_WIDTH_DEF = 16;
  localparam int STEP_WIDTH_DEF   = 20;

  localparam int AXIS_W      = 2;
  localparam int LANE_P_W    = 16;
  localparam int LANE_S_W    = 20;
  localparam int PREG_W      = 3 * LANE_P_W;
  localparam int SREG_W      = 3 * LANE_S_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SREG_W;
  localparam int PRESCALE_W  = 16;
  localparam int INCR_W      = PRESCALE_W + 1;
  localparam int COUNT_W     = 32;
  localparam int OUT_PER_W   = 16;
  localparam int OUT_CMP_W   = 15;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DESIRED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE    = 3'd4;

  typedef enum logic [2:0] {
    PH_STOP   = 3'd0,
    PH_START  = 3'd1,
    PH_ACCEL  = 3'd2,
    PH_CRUISE = 3'd3,
    PH_DECEL  = 3'd4,
    PH_HOLD   = 3'd5
  } phase_t;

  // stop_motion in bit 0, reload_valid in bit 1, phase in bits 4:2
  typedef struct packed {
    phase_t phase;
    logic   reload_valid;
    logic   stop_motion;
  } step_status_t;

endpackage
`default_nettype wire

### src/stepper_trapezoid_profile_unit.sv
// Top level of the stepper trapezoid profile unit.
`default_nettype none
// Takes one pulse-finished event per cycle, back to back, unless a held-off
// output stalls it, and returns one result per event: the axis state
// (period, edge count, acceleration count) is read from a registered-read
// memory in the transfer cycle, updated and written back as the event moves
// on, and the result sits in an output register the downstream side may
// hold off. Same-axis events in consecutive cycles are forwarded from the
// last write. Reset and start/accel writes need no clearing pass: valid bits
// make unwritten periods read as the seed and, after reset, zero counts.
// The user must write settings only while the unit is empty: not enforced.
module stepper_trapezoid_profile_unit #(
  parameter int NUM_AXES     = stpr_pkg::NUM_AXES_DEF,
  parameter int PERIOD_WIDTH = stpr_pkg::PERIOD_WIDTH_DEF,
  parameter int STEP_WIDTH   = stpr_pkg::STEP_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // steps_done[19:0], prescaler[35:20], zero fill
  input  wire logic [stpr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // axis[1:0]
  input  wire logic [stpr_pkg::AXIS_W-1:0]        in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // period[15:0], compare[30:16], count_reload[62:31], zero fill
  output logic      [stpr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // stop_motion[0], reload_valid[1], phase[4:2]
  output logic      [stpr_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [stpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [stpr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import stpr_pkg::*;

  localparam int AIDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [AXIS_W-1:0] AXIS_LIM = AXIS_W'(NUM_AXES);

  logic                    s1_vld_r, s1_vld_nxt;
  logic [AXIS_W-1:0]       s1_axis_r;
  logic [STEP_WIDTH-1:0]   s1_done_r;
  logic [PRESCALE_W-1:0]   s1_pre_r;
  logic                    s1_adv;
  logic                    s1_in_range;
  logic                    in_xfer;
  logic                    in_in_range;

  logic                    out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TUSER_W-1:0]  out_user_r;

  logic [PERIOD_WIDTH-1:0] des, start, minp, acc, seed;
  logic [STEP_WIDTH-1:0]   move;
  logic                    reseed;

  logic [PERIOD_WIDTH-1:0] cur;
  logic [COUNT_W-1:0]      edge_cnt, acc_cnt;

  step_status_t            status;
  logic [PERIOD_WIDTH-1:0] period;
  logic [OUT_PER_W-1:0]    period_o;
  logic [COUNT_W-1:0]      count_reload;
  logic                    calc_wr;
  logic [PERIOD_WIDTH-1:0] nxt_cur;
  logic [COUNT_W-1:0]      nxt_edge, nxt_acc;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready   = !s1_vld_r || s1_adv;
  assign in_xfer     = in_tvalid && in_tready;
  assign in_in_range = (in_tuser < AXIS_LIM);
  assign s1_in_range = (s1_axis_r < AXIS_LIM);

  assign s1_vld_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_axis_r <= in_tuser;
      s1_done_r <= in_tdata[STEP_WIDTH-1:0];
      s1_pre_r  <= in_tdata[LANE_S_W +: PRESCALE_W];
    end
    if (s1_adv) begin
      out_data_r <= {1'b0, count_reload, period_o[OUT_PER_W-1:1], period_o};
      out_user_r <= status;
    end
  end

  assign period_o = OUT_PER_W'(period);

  stpr_cfg #(
    .NUM_AXES     (NUM_AXES),
    .PERIOD_WIDTH (PERIOD_WIDTH),
    .STEP_WIDTH   (STEP_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sel_axis  (s1_axis_r[AIDX_W-1:0]),
    .des       (des),
    .start     (start),
    .minp      (minp),
    .acc       (acc),
    .seed      (seed),
    .move      (move),
    .reseed    (reseed)
  );

  stpr_state_mem #(
    .NUM_AXES     (NUM_AXES),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .reseed   (reseed),
    .rd_en    (in_xfer && in_in_range),
    .rd_addr  (in_tuser[AIDX_W-1:0]),
    .seed     (seed),
    .cur      (cur),
    .edge_cnt (edge_cnt),
    .acc_cnt  (acc_cnt),
    .wr_en    (s1_adv && calc_wr),
    .wr_cur   (nxt_cur),
    .wr_edge  (nxt_edge),
    .wr_acc   (nxt_acc)
  );

  stpr_calc #(
    .PERIOD_WIDTH (PERIOD_WIDTH),
    .STEP_WIDTH   (STEP_WIDTH)
  ) u_calc (
    .in_range     (s1_in_range),
    .done         (s1_done_r),
    .incr         (INCR_W'(s1_pre_r) + INCR_W'(1)),
    .move         (move),
    .des          (des),
    .start        (start),
    .minp         (minp),
    .acc          (acc),
    .seed         (seed),
    .cur          (cur),
    .edge_cnt     (edge_cnt),
    .acc_cnt      (acc_cnt),
    .status       (status),
    .period       (period),
    .count_reload (count_reload),
    .wr_en        (calc_wr),
    .nxt_cur      (nxt_cur),
    .nxt_edge     (nxt_edge),
    .nxt_acc      (nxt_acc)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

### src/stpr_cfg.sv
// Configuration registers and per-axis lane selection.
`default_nettype none
module stpr_cfg #(
  parameter int NUM_AXES     = stpr_pkg::NUM_AXES_DEF,
  parameter int PERIOD_WIDTH = stpr_pkg::PERIOD_WIDTH_DEF,
  parameter int STEP_WIDTH   = stpr_pkg::STEP_WIDTH_DEF,
  localparam int AIDX_W      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [stpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stpr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [AIDX_W-1:0]                sel_axis,
  output logic      [PERIOD_WIDTH-1:0]          des,
  output logic      [PERIOD_WIDTH-1:0]          start,
  output logic      [PERIOD_WIDTH-1:0]          minp,
  output logic      [PERIOD_WIDTH-1:0]          acc,
  output logic      [PERIOD_WIDTH-1:0]          seed,
  output logic      [STEP_WIDTH-1:0]            move,
  output logic                                  reseed
);
  import stpr_pkg::*;

  logic [PREG_W-1:0] des_r, des_nxt;
  logic [PREG_W-1:0] start_r, start_nxt;
  logic [PREG_W-1:0] min_r, min_nxt;
  logic [PREG_W-1:0] acc_r, acc_nxt;
  logic [SREG_W-1:0] move_r, move_nxt;
  logic              reseed_w;

  always_comb begin
    des_nxt   = des_r;
    start_nxt = start_r;
    min_nxt   = min_r;
    acc_nxt   = acc_r;
    move_nxt  = move_r;
    reseed_w  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DESIRED: des_nxt = cfg_wdata[PREG_W-1:0];
        CFG_START: begin
          start_nxt = cfg_wdata[PREG_W-1:0];
          reseed_w  = 1'b1;
        end
        CFG_MIN:     min_nxt = cfg_wdata[PREG_W-1:0];
        CFG_ACCEL: begin
          acc_nxt  = cfg_wdata[PREG_W-1:0];
          reseed_w = 1'b1;
        end
        CFG_MOVE:    move_nxt = cfg_wdata[SREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      des_r   <= '0;
      start_r <= '0;
      min_r   <= '0;
      acc_r   <= '0;
      move_r  <= '0;
    end else begin
      des_r   <= des_nxt;
      start_r <= start_nxt;
      min_r   <= min_nxt;
      acc_r   <= acc_nxt;
      move_r  <= move_nxt;
    end
  end

  assign des    = des_r[LANE_P_W*sel_axis +: PERIOD_WIDTH];
  assign start  = start_r[LANE_P_W*sel_axis +: PERIOD_WIDTH];
  assign minp   = min_r[LANE_P_W*sel_axis +: PERIOD_WIDTH];
  assign acc    = acc_r[LANE_P_W*sel_axis +: PERIOD_WIDTH];
  assign move   = move_r[LANE_S_W*sel_axis +: STEP_WIDTH];
  assign seed   = (start > acc) ? (start - acc) : '0;
  assign reseed = reseed_w;

endmodule
`default_nettype wire

### src/stpr_state_mem.sv
// Per-axis state memory with valid bits and write-to-read forwarding.
`default_nettype none
module stpr_state_mem #(
  parameter int NUM_AXES     = stpr_pkg::NUM_AXES_DEF,
  parameter int PERIOD_WIDTH = stpr_pkg::PERIOD_WIDTH_DEF,
  localparam int AIDX_W      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           reseed,
  input  wire logic                           rd_en,
  input  wire logic [AIDX_W-1:0]              rd_addr,
  input  wire logic [PERIOD_WIDTH-1:0]        seed,
  output logic      [PERIOD_WIDTH-1:0]        cur,
  output logic      [stpr_pkg::COUNT_W-1:0]   edge_cnt,
  output logic      [stpr_pkg::COUNT_W-1:0]   acc_cnt,
  input  wire logic                           wr_en,
  input  wire logic [PERIOD_WIDTH-1:0]        wr_cur,
  input  wire logic [stpr_pkg::COUNT_W-1:0]   wr_edge,
  input  wire logic [stpr_pkg::COUNT_W-1:0]   wr_acc
);
  import stpr_pkg::*;

  localparam int WORD_W = PERIOD_WIDTH + 2 * COUNT_W;

  logic [WORD_W-1:0]   mem [NUM_AXES];
  logic [WORD_W-1:0]   rd_q_r;
  logic [AIDX_W-1:0]   rd_addr_r;
  logic [WORD_W-1:0]   wr_word;
  logic [NUM_AXES-1:0] per_vld_r, per_vld_nxt;
  logic [NUM_AXES-1:0] cnt_vld_r, cnt_vld_nxt;
  logic                byp_vld_r, byp_vld_nxt;
  logic [AIDX_W-1:0]   byp_addr_r;
  logic [WORD_W-1:0]   byp_word_r;
  logic                hit;
  logic [PERIOD_WIDTH-1:0] q_cur;
  logic [COUNT_W-1:0]  q_edge;
  logic [COUNT_W-1:0]  q_acc;

  assign wr_word = {wr_cur, wr_edge, wr_acc};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_r] <= wr_word;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) begin
      byp_addr_r <= rd_addr_r;
      byp_word_r <= wr_word;
    end
  end

  always_comb begin
    per_vld_nxt = per_vld_r;
    cnt_vld_nxt = cnt_vld_r;
    byp_vld_nxt = byp_vld_r;
    if (wr_en) begin
      per_vld_nxt[rd_addr_r] = 1'b1;
      cnt_vld_nxt[rd_addr_r] = 1'b1;
      byp_vld_nxt            = 1'b1;
    end
    if (reseed) begin
      per_vld_nxt = '0;
      byp_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_vld_r <= '0;
      cnt_vld_r <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      per_vld_r <= per_vld_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      byp_vld_r <= byp_vld_nxt;
    end
  end

  // last write went to the axis being read, also when it landed at the edge this one was read
  assign hit = byp_vld_r && (byp_addr_r == rd_addr_r);

  assign {q_cur, q_edge, q_acc} = hit ? byp_word_r : rd_q_r;

  assign cur      = (hit || per_vld_r[rd_addr_r]) ? q_cur  : seed;
  assign edge_cnt = (hit || cnt_vld_r[rd_addr_r]) ? q_edge : '0;
  assign acc_cnt  = (hit || cnt_vld_r[rd_addr_r]) ? q_acc  : '0;

endmodule
`default_nettype wire

### src/stpr_calc.sv
// Profile step: stop, start, accelerate, cruise, decelerate or hold for one event.
`default_nettype none
module stpr_calc #(
  parameter int PERIOD_WIDTH = stpr_pkg::PERIOD_WIDTH_DEF,
  parameter int STEP_WIDTH   = stpr_pkg::STEP_WIDTH_DEF
) (
  input  wire logic                          in_range,
  input  wire logic [STEP_WIDTH-1:0]         done,
  input  wire logic [stpr_pkg::INCR_W-1:0]   incr,
  input  wire logic [STEP_WIDTH-1:0]         move,
  input  wire logic [PERIOD_WIDTH-1:0]       des,
  input  wire logic [PERIOD_WIDTH-1:0]       start,
  input  wire logic [PERIOD_WIDTH-1:0]       minp,
  input  wire logic [PERIOD_WIDTH-1:0]       acc,
  input  wire logic [PERIOD_WIDTH-1:0]       seed,
  input  wire logic [PERIOD_WIDTH-1:0]       cur,
  input  wire logic [stpr_pkg::COUNT_W-1:0]  edge_cnt,
  input  wire logic [stpr_pkg::COUNT_W-1:0]  acc_cnt,
  output stpr_pkg::step_status_t             status,
  output logic      [PERIOD_WIDTH-1:0]       period,
  output logic      [stpr_pkg::COUNT_W-1:0]  count_reload,
  output logic                               wr_en,
  output logic      [PERIOD_WIDTH-1:0]       nxt_cur,
  output logic      [stpr_pkg::COUNT_W-1:0]  nxt_edge,
  output logic      [stpr_pkg::COUNT_W-1:0]  nxt_acc
);
  import stpr_pkg::*;

  logic [STEP_WIDTH-1:0]   half;
  logic                    early;
  logic [PERIOD_WIDTH-1:0] dn;
  logic [PERIOD_WIDTH-1:0] dn_clip;
  logic [PERIOD_WIDTH:0]   up;
  logic [PERIOD_WIDTH-1:0] up_clip;
  logic [COUNT_W-1:0]      move_w;
  logic [COUNT_W-1:0]      tail;
  logic [COUNT_W-1:0]      edge_sum;
  phase_t                  phase;
  logic                    stop;

  assign half     = move >> 1;
  assign early    = (done <= half);
  assign dn       = (cur > acc) ? (cur - acc) : '0;
  assign dn_clip  = (dn <= minp) ? minp : dn;
  assign up       = {1'b0, cur} + {1'b0, acc};
  assign up_clip  = (up >= {1'b0, seed}) ? start : up[PERIOD_WIDTH-1:0];
  assign move_w   = COUNT_W'(move);
  assign tail     = (move_w > acc_cnt) ? (move_w - acc_cnt) : '0;
  assign edge_sum = edge_cnt + COUNT_W'(incr);

  always_comb begin
    phase    = PH_HOLD;
    stop     = 1'b0;
    period   = '0;
    nxt_cur  = cur;
    nxt_edge = edge_sum;
    nxt_acc  = acc_cnt;
    if (done >= move) begin
      nxt_edge = '0;
      nxt_acc  = '0;
      stop     = 1'b1;
      phase    = PH_STOP;
    end else begin
      if (des > start) begin
        period = start;
        phase  = PH_START;
      end
      if ((des < dn) && early) begin
        nxt_cur = dn_clip;
        period  = dn_clip;
        phase   = PH_ACCEL;
        nxt_acc = acc_cnt + COUNT_W'(incr);
      end else if ((des >= dn) && (cur > des) && early) begin
        period = des;
        phase  = PH_CRUISE;
      end else if (COUNT_W'(done) >= tail) begin
        nxt_cur = up_clip;
        period  = up_clip;
        phase   = PH_DECEL;
      end
    end
    if (!in_range) begin
      phase  = PH_HOLD;
      stop   = 1'b0;
      period = '0;
    end
  end

  assign status.stop_motion  = stop;
  assign status.reload_valid = (phase != PH_STOP) && (phase != PH_HOLD);
  assign status.phase        = phase;
  assign count_reload        = status.reload_valid ? edge_sum : '0;
  assign wr_en               = in_range;

endmodule
`default_nettype wire
